@@ sv/dcc_pkg.sv @@
`default_nettype none

package dcc_pkg;

	localparam int COLOR_BITS_DEF = 16;
	localparam int PIXEL_W = 16;
	localparam int COUNT_W = 17;
	localparam int OUT_DATA_W = 24;
	localparam int BIT_SEL_BITS = 3;
	localparam int LANE_BITS = 8;
	localparam int EPOCH_BITS = 8;
	localparam logic [COUNT_W-1:0] CAP_RESET = 17'h10000;

	typedef struct packed {
		logic [EPOCH_BITS-1:0] tag;
		logic [LANE_BITS-1:0] bits;
	} seen_word_t;

	typedef struct packed {
		logic cap;
		logic [COUNT_W-1:0] count;
	} result_t;

	typedef enum logic {
		SW_CLEAR,
		SW_RUN
	} sweep_state_t;

endpackage

`default_nettype wire

@@ sv/distinct_color_counter.sv @@
`default_nettype none

// Counts the distinct colours in a frame of pixels, one pixel per transaction with tlast on the
// last pixel, and returns the count with a cap flag on the last one. It takes one pixel per
// cycle while s_axis_tready is high: the seen bits live in a memory of 8-bit words, each
// tagged with a frame number; a pixel reads its word on acceptance and, if its colour is new
// and counting has not stopped, writes it back in the next cycle, with the word just written
// forwarded to the next pixel. The result reaches the output buffer in the cycle after the
// last pixel is accepted. That buffer holds two results, and s_axis_tready drops whenever a
// result would find it full. As the frame number is 8 bits wide, the memory is cleared after
// reset and again after every 256th frame, writing all 2**(COLOR_BITS-3) words (8192 by default);
// s_axis_tready stays low while a clear starts and runs, but cfg_we may still write the cap.

module distinct_color_counter
	import dcc_pkg::*;
#(
	parameter int COLOR_BITS = COLOR_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [PIXEL_W-1:0]    s_axis_tdata,   // pixel_color
	input  wire logic                  s_axis_tlast,   // frame_end
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // distinct_count, zero padding
	output logic [0:0]                 m_axis_tuser,   // cap_reached
	input  wire logic                  cfg_we,
	input  wire logic [COUNT_W-1:0]    cfg_wdata
);

	localparam int ADDR_BITS = COLOR_BITS - BIT_SEL_BITS;
	localparam logic [COUNT_W-1:0] COLOR_SPACE = COUNT_W'(2**COLOR_BITS);

	logic [COUNT_W-1:0] cap_q;
	logic [COUNT_W-1:0] count_q;
	logic stopped_q;
	logic [EPOCH_BITS-1:0] epoch_q;

	logic vld_s1;
	logic [ADDR_BITS-1:0] addr_s1;
	logic [BIT_SEL_BITS-1:0] lane_s1;
	logic last_s1;

	logic fwd_vld_q;
	logic [ADDR_BITS-1:0] fwd_addr_q;
	seen_word_t fwd_word_q;

	logic acc;
	logic sweep_busy;
	logic sweep_start;
	logic [ADDR_BITS-1:0] sweep_addr;
	logic room_next;
	logic push;
	logic pop;
	result_t res;
	result_t out_res;

	seen_word_t rd_word;
	seen_word_t cur_word;
	seen_word_t wr_word;
	logic [LANE_BITS-1:0] cur_bits;
	logic do_count;
	logic hit;
	logic [COUNT_W-1:0] cnt_inc;

	logic mem_we;
	logic [ADDR_BITS-1:0] mem_waddr;
	seen_word_t mem_wdata;

	assign acc = s_axis_tvalid && s_axis_tready;
	assign pop = m_axis_tvalid && m_axis_tready;
	assign push = vld_s1 && last_s1;
	assign sweep_start = push && (epoch_q == '1);
	assign s_axis_tready = !sweep_busy && !sweep_start && room_next;

	assign cur_word = (fwd_vld_q && fwd_addr_q == addr_s1) ? fwd_word_q : rd_word;
	assign cur_bits = (cur_word.tag == epoch_q) ? cur_word.bits : '0;
	assign do_count = vld_s1 && !stopped_q && !cur_bits[lane_s1];
	assign cnt_inc = COUNT_W'(count_q + 1'b1);
	assign hit = (cnt_inc >= cap_q);

	assign wr_word.tag = epoch_q;
	assign wr_word.bits = cur_bits | (LANE_BITS'(1) << lane_s1);

	assign res.count = do_count ? cnt_inc : count_q;
	assign res.cap = stopped_q || (do_count && hit);

	assign mem_we = sweep_busy || do_count;
	assign mem_waddr = sweep_busy ? sweep_addr : addr_s1;
	assign mem_wdata = sweep_busy ? seen_word_t'('0) : wr_word;

	dcc_seen_mem #(
		.ADDR_BITS(ADDR_BITS)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(mem_waddr),
		.wr_data(mem_wdata),
		.rd_en  (acc),
		.rd_addr(s_axis_tdata[COLOR_BITS-1:BIT_SEL_BITS]),
		.rd_data(rd_word)
	);

	dcc_sweep #(
		.ADDR_BITS(ADDR_BITS)
	) u_sweep (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sweep_start),
		.busy  (sweep_busy),
		.addr  (sweep_addr)
	);

	dcc_out_buf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(res),
		.pop      (pop),
		.out_valid(m_axis_tvalid),
		.out_data (out_res),
		.room_next(room_next)
	);

	assign m_axis_tdata = {{(OUT_DATA_W - COUNT_W){1'b0}}, out_res.count};
	assign m_axis_tuser = out_res.cap;

	always_ff @(posedge clk) begin
		if (acc) begin
			addr_s1 <= s_axis_tdata[COLOR_BITS-1:BIT_SEL_BITS];
			lane_s1 <= s_axis_tdata[BIT_SEL_BITS-1:0];
			last_s1 <= s_axis_tlast;
		end
		if (do_count) begin
			fwd_addr_q <= addr_s1;
			fwd_word_q <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			count_q <= '0;
			stopped_q <= 1'b0;
			epoch_q <= '0;
			vld_s1 <= 1'b0;
			fwd_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			vld_s1 <= acc;
			fwd_vld_q <= do_count;
			if (push) begin
				count_q <= '0;
				stopped_q <= 1'b0;
				epoch_q <= EPOCH_BITS'(epoch_q + 1'b1);
			end else if (do_count) begin
				count_q <= cnt_inc;
				if (hit) begin
					stopped_q <= 1'b1;
				end
			end
		end
	end

	a_stop_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> (count_q != '0))
		else $error("Counting stopped with a zero count.");

	a_no_pixel_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_busy |-> !vld_s1)
		else $error("Pixel in flight while the seen memory is cleared.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COLOR_SPACE)
		else $error("Distinct count exceeds the colour space.");

endmodule

`default_nettype wire

@@ sv/dcc_seen_mem.sv @@
`default_nettype none

module dcc_seen_mem
	import dcc_pkg::*;
#(
	parameter int ADDR_BITS = COLOR_BITS_DEF - BIT_SEL_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [ADDR_BITS-1:0] wr_addr,
	input  wire seen_word_t           wr_data,
	input  wire logic                 rd_en,
	input  wire logic [ADDR_BITS-1:0] rd_addr,
	output seen_word_t                rd_data
);

	seen_word_t mem_q [2**ADDR_BITS];
	seen_word_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ sv/dcc_sweep.sv @@
`default_nettype none

module dcc_sweep
	import dcc_pkg::*;
#(
	parameter int ADDR_BITS = COLOR_BITS_DEF - BIT_SEL_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	output logic [ADDR_BITS-1:0]      addr
);

	sweep_state_t state_q, state_d;
	logic [ADDR_BITS-1:0] addr_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			SW_CLEAR: begin
				if (addr_q == '1) begin
					state_d = SW_RUN;
				end
			end
			SW_RUN: begin
				if (start) begin
					state_d = SW_CLEAR;
				end
			end
			default: state_d = SW_CLEAR;
		endcase
	end

	always_comb begin
		case (state_q)
			SW_CLEAR: busy = 1'b1;
			SW_RUN:   busy = 1'b0;
			default:  busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SW_CLEAR;
			addr_q <= '0;
		end else begin
			state_q <= state_d;
			if (busy) begin
				addr_q <= ADDR_BITS'(addr_q + 1'b1);
			end
		end
	end

	assign addr = addr_q;

endmodule

`default_nettype wire

@@ sv/dcc_out_buf.sv @@
`default_nettype none

module dcc_out_buf
	import dcc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	input  wire logic    pop,
	output logic         out_valid,
	output result_t      out_data,
	output logic         room_next
);

	result_t ent_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;

	assign out_valid = (cnt_q != 2'd0);
	assign out_data = ent_q[rd_ptr_q];

	always_comb begin
		case (cnt_q)
			2'd0:    room_next = 1'b1;
			2'd1:    room_next = !push || pop;
			2'd2:    room_next = pop && !push;
			default: room_next = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && push) |-> pop)
		else $error("Result buffer overflow.");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> out_valid)
		else $error("Result buffer read while empty.");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("Result buffer count out of range.");

endmodule

`default_nettype wire

@@ tb/sv/tb_distinct_color_counter.sv @@
module tb_distinct_color_counter;
	import dcc_pkg::*;

	typedef struct packed {
		logic [PIXEL_W-1:0] color;
		logic last;
		logic hold;
	} pixel_item_t;

	typedef enum logic [1:0] {
		PICK_ANY,
		PICK_POOL,
		PICK_WORD
	} color_pick_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [PIXEL_W-1:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;
	logic cfg_we = 1'b0;
	logic [COUNT_W-1:0] cfg_wdata = '0;

	distinct_color_counter dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	pixel_item_t pending_pixels[$];
	result_t expected_results[$];
	int queued_total = 0;
	int mismatch_count = 0;
	logic pix_taken = 1'b0;
	logic steady = 1'b0;
	int burst_left = 1;
	int gap_left = 0;
	int ready_left = 0;
	logic [PIXEL_W-1:0] pool_colors[8];

	// Colour counter state as the testbench sees it.
	bit seen_color[0:(1 << PIXEL_W) - 1];
	logic [PIXEL_W-1:0] touched_colors[$];
	logic [COUNT_W-1:0] count_limit = CAP_RESET;
	logic [COUNT_W-1:0] frame_count = '0;
	logic count_halted = 1'b0;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic count_pixel(input logic [PIXEL_W-1:0] color, input logic last);
		result_t res;
		if (!count_halted && !seen_color[color]) begin
			seen_color[color] = 1'b1;
			touched_colors.push_back(color);
			frame_count = frame_count + 1'b1;
			if (frame_count >= count_limit)
				count_halted = 1'b1;
		end
		if (last) begin
			res.count = frame_count;
			res.cap = count_halted;
			expected_results.push_back(res);
			foreach (touched_colors[i])
				seen_color[touched_colors[i]] = 1'b0;
			touched_colors.delete();
			frame_count = '0;
			count_halted = 1'b0;
		end
	endtask

	task automatic add_pixel(input logic [PIXEL_W-1:0] color, input logic last,
			input logic hold);
		pixel_item_t item;
		item.color = color;
		item.last = last;
		item.hold = hold;
		pending_pixels.push_back(item);
		queued_total++;
	endtask

	task automatic add_random_frame();
		int len;
		color_pick_t pick;
		logic [PIXEL_W-1:0] color;
		case ($urandom_range(0, 9))
			0, 1, 2: len = $urandom_range(1, 2);
			9: len = $urandom_range(9, 40);
			default: len = $urandom_range(1, 8);
		endcase
		pick = color_pick_t'($urandom_range(0, 2));
		for (int i = 0; i < len; i++) begin
			case (pick)
				PICK_POOL: color = pool_colors[$urandom_range(0, 7)];
				PICK_WORD: color = {pool_colors[0][PIXEL_W-1:3], 3'($urandom_range(0, 7))};
				default: color = PIXEL_W'($urandom);
			endcase
			add_pixel(color, i == len - 1, $urandom_range(0, 299) == 0);
		end
	endtask

	task automatic drain();
		while (pending_pixels.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_cap(input logic [COUNT_W-1:0] value);
		drain();
		repeat (8) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(negedge clk) begin : drive_pixels
		pixel_item_t nxt;
		logic send;
		send = 1'b0;
		if (arst_n && (!s_axis_tvalid || pix_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_pixels.size() != 0 &&
					(!pending_pixels[0].hold || expected_results.size() == 0)) begin
				nxt = pending_pixels.pop_front();
				send = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
			s_axis_tvalid <= send;
			if (send) begin
				s_axis_tdata <= nxt.color;
				s_axis_tlast <= nxt.last;
			end
		end
	end

	always @(negedge clk) begin : drive_ready
		logic ready;
		if (arst_n) begin
			if (steady) begin
				m_axis_tready <= 1'b1;
			end else if (ready_left > 0) begin
				ready_left--;
			end else begin
				ready = $urandom_range(0, 3) != 0;
				ready_left = ready ? $urandom_range(0, 30) : $urandom_range(0, 12);
				m_axis_tready <= ready;
			end
		end
	end

	always @(posedge clk) begin : watch_ports
		result_t want;
		if (arst_n) begin
			pix_taken <= s_axis_tvalid && s_axis_tready;
			if (cfg_we)
				count_limit = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready)
				count_pixel(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result: data %h flag %b",
						m_axis_tdata, m_axis_tuser));
				end else begin
					want = expected_results.pop_front();
					if (m_axis_tdata !== {{(OUT_DATA_W - COUNT_W){1'b0}}, want.count})
						report_mismatch($sformatf("count: got %h, expected %0d",
							m_axis_tdata, want.count));
					if (m_axis_tuser[0] !== want.cap)
						report_mismatch($sformatf("cap flag: got %b, expected %b",
							m_axis_tuser, want.cap));
				end
			end
		end
	end

	initial begin : run_test
		int rand_goal;
		int frames;
		logic [COUNT_W-1:0] cap;
		foreach (pool_colors[i])
			pool_colors[i] = PIXEL_W'($urandom);
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		add_pixel(16'h0000, 1'b1, 1'b0);
		add_pixel(16'hFFFF, 1'b1, 1'b0);
		add_pixel(16'h0000, 1'b0, 1'b0);
		add_pixel(16'h0000, 1'b0, 1'b0);
		add_pixel(16'hFFFF, 1'b0, 1'b0);
		add_pixel(16'h0001, 1'b0, 1'b0);
		add_pixel(16'h0000, 1'b1, 1'b0);
		for (int i = 0; i < 8; i++)
			add_pixel(16'h0010 + 16'(i), 1'b0, 1'b0);
		add_pixel(16'h0010, 1'b1, 1'b0);
		add_pixel(16'hAAAA, 1'b0, 1'b0);
		add_pixel(16'h5555, 1'b0, 1'b0);
		add_pixel(16'h5555, 1'b1, 1'b1);
		add_pixel(16'h1234, 1'b0, 1'b0);
		add_pixel(16'h5678, 1'b1, 1'b0);
		drain();

		// Frames back to back with the receiver always ready.
		steady = 1'b1;
		repeat (20) add_random_frame();
		drain();
		steady = 1'b0;

		set_cap('0);
		add_pixel(16'h0007, 1'b0, 1'b0);
		add_pixel(16'h0007, 1'b0, 1'b0);
		add_pixel(16'h0009, 1'b0, 1'b0);
		add_pixel(16'hFFFF, 1'b1, 1'b0);
		add_pixel(16'h8000, 1'b1, 1'b0);
		set_cap(17'd1);
		add_pixel(16'h0003, 1'b0, 1'b0);
		add_pixel(16'h0004, 1'b1, 1'b0);
		add_pixel(16'h4321, 1'b1, 1'b0);
		set_cap('1);
		repeat (10) add_random_frame();
		set_cap(17'd2);
		add_pixel(16'h0001, 1'b0, 1'b0);
		add_pixel(16'h0002, 1'b0, 1'b0);
		add_pixel(16'h0003, 1'b1, 1'b0);
		add_pixel(16'h0001, 1'b0, 1'b0);
		add_pixel(16'h0001, 1'b0, 1'b0);
		add_pixel(16'h0002, 1'b1, 1'b0);
		add_pixel(16'h0005, 1'b1, 1'b0);

		rand_goal = 1750;
		while (queued_total < rand_goal) begin
			case ($urandom_range(0, 5))
				0: cap = COUNT_W'($urandom_range(0, 4));
				1, 2: cap = COUNT_W'($urandom_range(5, 20));
				3: cap = COUNT_W'($urandom_range(0, 131071));
				4: cap = CAP_RESET;
				default: cap = COUNT_W'($urandom_range(65535, 131071));
			endcase
			set_cap(cap);
			frames = $urandom_range(10, 40);
			repeat (frames) add_random_frame();
		end

		drain();
		repeat (20) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		if (mismatch_count == 0)
			$display("** distinct_color_counter: PASSED **");
		else
			$display("** distinct_color_counter: FAILED **");
		$finish;
	end

	initial begin : watchdog
		#40000000;
		$display("** distinct_color_counter: FAILED **");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/dcc_pkg.sv
sv/dcc_seen_mem.sv
sv/dcc_sweep.sv
sv/dcc_out_buf.sv
sv/distinct_color_counter.sv
tb/sv/tb_distinct_color_counter.sv
